// File: rtl/bpc_pkg.sv
`timescale 1ns / 1ps
package bpc_pkg;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DIV0 = 2'd1,
    STAT_SAT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4
  } cfg_reg_t;

  localparam int  COEFF_W   = 32;
  localparam int  UP_MAXW   = 19;
  localparam int  PQ_W      = 31;
  localparam int  B4_MAGW   = 50;
  localparam longint P_HUGE = 64'sh0000_0000_8000_0000;
  localparam logic [12:0] C_X2  = 13'd7357;
  localparam logic [11:0] C_X1  = 12'd3038;
  localparam logic [19:0] P_MAX = 20'hFFFFF;

  // travels with the temperature divider
  typedef struct packed {
    logic               terr;
    logic               qneg;
    logic signed [18:0] x1;
    logic [UP_MAXW-1:0] up;
  } tside_t;

  // travels through the pressure polynomial stages
  typedef struct packed {
    logic               terr;
    logic               tsat;
    logic [15:0]        tout;
    logic [UP_MAXW-1:0] up;
  } ctx_t;

  // travels with the pressure divider
  typedef struct packed {
    logic        err;
    logic        case2;
    logic        neg;
    logic        ovf;
    logic        tsat;
    logic [15:0] tout;
  } pside_t;

  typedef struct packed {
    logic [15:0] temp;
    logic [19:0] pres;
    status_t     st;
  } result_t;

endpackage

// File: rtl/bpc_div.sv
`timescale 1ns / 1ps
module bpc_div #(
  parameter int NW = 27,
  parameter int DW = 20,
  parameter int QW = 27,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem [QW];
  logic [QW-1:0] qt  [QW];
  logic [DW-1:0] dv  [QW];
  logic [SW-1:0] sd  [QW];
  logic [QW-1:0] vld;

  logic [NW-1:0] rem_next [QW];
  logic [QW-1:0] qt_next  [QW];

  // one quotient bit per stage, msb first
  always_comb begin
    logic [NW-1:0] r_cur;
    logic [QW-1:0] q_cur;
    logic [DW-1:0] d_cur;
    logic [CW-1:0] trial;
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        r_cur = num;
        q_cur = '0;
        d_cur = den;
      end else begin
        r_cur = rem[i-1];
        q_cur = qt[i-1];
        d_cur = dv[i-1];
      end
      trial = CW'(d_cur) << (QW - 1 - i);
      if (CW'(r_cur) >= trial) begin
        rem_next[i] = NW'(CW'(r_cur) - trial);
        qt_next[i]  = q_cur | (QW'(1) << (QW - 1 - i));
      end else begin
        rem_next[i] = r_cur;
        qt_next[i]  = q_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        rem[i] <= rem_next[i];
        qt[i]  <= qt_next[i];
        if (i == 0) begin
          dv[i] <= den;
          sd[i] <= side_in;
        end else begin
          dv[i] <= dv[i-1];
          sd[i] <= sd[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-2:0], in_valid};
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = qt[QW-1];
  assign side_out  = sd[QW-1];

endmodule

// File: rtl/barometric_pressure_compensation_unit.sv
`timescale 1ns / 1ps
// channel   signals                                           direction
// input     in_valid/in_ready, raw_temperature, raw_pressure_bytes request in
// output    out_valid/out_ready, temperature_tenths,           result out
//           pressure_pa, status
// config    cfg_write, cfg_index, cfg_data                     write only
//
// one request per cycle while the output queue is not full; each request passes
// through the 27-stage temperature divider, the 31-stage pressure divider and
// the arithmetic stages around them
// synchronous reset clears valid bits, coefficients and the output queue
// a two-entry output queue takes results; the pipe stalls as a whole only
// when both entries are full
module barometric_pressure_compensation_unit
  import bpc_pkg::*;
#(
  parameter int OVERSAMPLING = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] raw_temperature,
  input  logic [23:0] raw_pressure_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] temperature_tenths,
  output logic [19:0] pressure_pa,
  output logic [1:0]  status,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [COEFF_W-1:0] cfg_data
);

  localparam int UPW  = 16 + OVERSAMPLING;
  localparam int B3SW = 56 + OVERSAMPLING;
  localparam int B3W  = B3SW - 2;
  localparam int B7W  = B3W + 18;
  localparam int PNW  = B7W + 1;
  localparam int PCW  = (PNW > B4_MAGW + PQ_W) ? PNW : B4_MAGW + PQ_W;
  localparam logic signed [16:0] PMUL = 17'(50000 >> OVERSAMPLING);
  localparam logic signed [B7W-1:0] HUGE_B7 = B7W'(P_HUGE);

  // coefficients
  logic [COEFF_W-1:0] coef_ac12, coef_ac34, coef_ac56, coef_b12, coef_mcmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_ac12 <= '0;
      coef_ac34 <= '0;
      coef_ac56 <= '0;
      coef_b12  <= '0;
      coef_mcmd <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_AC1_AC2: coef_ac12 <= cfg_data;
        REG_AC3_AC4: coef_ac34 <= cfg_data;
        REG_AC5_AC6: coef_ac56 <= cfg_data;
        REG_B1_B2:   coef_b12  <= cfg_data;
        REG_MC_MD:   coef_mcmd <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0] ac4, ac5, ac6;

  assign ac1 = $signed(coef_ac12[31:16]);
  assign ac2 = $signed(coef_ac12[15:0]);
  assign ac3 = $signed(coef_ac34[31:16]);
  assign ac4 = coef_ac34[15:0];
  assign ac5 = coef_ac56[31:16];
  assign ac6 = coef_ac56[15:0];
  assign b1  = $signed(coef_b12[31:16]);
  assign b2  = $signed(coef_b12[15:0]);
  assign mc  = $signed(coef_mcmd[31:16]);
  assign md  = $signed(coef_mcmd[15:0]);

  // global advance, held only while the output queue is full
  logic [1:0] cnt;
  logic       adv;
  assign adv      = (cnt != 2'd2);
  assign in_ready = adv;

  // temperature front end
  logic               v1, v2, v3;
  logic signed [16:0] d1;
  logic [UPW-1:0]     up1, up2;
  logic signed [33:0] m2;
  logic [26:0]        tnum3;
  logic [19:0]        tden3;
  tside_t             ts3;

  logic signed [18:0] x1_s3;
  logic signed [19:0] tden_s3;
  logic [15:0]        mc_mag;

  assign x1_s3   = $signed(m2[33:15]);
  assign tden_s3 = 20'(x1_s3) + 20'(md);
  assign mc_mag  = mc[15] ? 16'(-mc) : mc;

  always_ff @(posedge clk) begin
    if (adv) begin
      d1    <= $signed({1'b0, raw_temperature}) - $signed({1'b0, ac6});
      up1   <= raw_pressure_bytes[23 -: UPW];
      m2    <= d1 * $signed({1'b0, ac5});
      up2   <= up1;
      tnum3 <= {mc_mag, 11'b0};
      tden3 <= tden_s3[19] ? 20'(-tden_s3) : tden_s3;
      ts3.terr <= (tden_s3 == 20'sd0);
      ts3.qneg <= mc[15] ^ tden_s3[19];
      ts3.x1   <= x1_s3;
      ts3.up   <= UP_MAXW'(up2);
    end
  end

  logic        td_valid;
  logic [26:0] td_q;
  tside_t      td_side;

  bpc_div #(.NW(27), .DW(20), .QW(27), .SW($bits(tside_t))) u_tdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v3),
    .num      (tnum3),
    .den      (tden3),
    .side_in  (ts3),
    .out_valid(td_valid),
    .quo      (td_q),
    .side_out (td_side)
  );

  // P1: b5, temperature, b6
  logic signed [27:0] x2_p;
  logic signed [28:0] b5_p;
  logic signed [29:0] tsum_p;
  logic signed [25:0] t_p;
  logic               tsat_p;
  logic [15:0]        tout_p;

  assign x2_p   = td_side.qneg ? -$signed({1'b0, td_q}) : $signed({1'b0, td_q});
  assign b5_p   = 29'(td_side.x1) + 29'(x2_p);
  assign tsum_p = 30'(b5_p) + 30'sd8;
  assign t_p    = $signed(tsum_p[29:4]);
  assign tsat_p = (t_p > 26'sd32767) || (t_p < -26'sd32768);
  assign tout_p = (t_p > 26'sd32767) ? 16'h7FFF :
                  (t_p < -26'sd32768) ? 16'h8000 : t_p[15:0];

  logic vp1, vp2, vp3, vp4, vp5, vp6, vp7, vp8;
  ctx_t cx1, cx2, cx3, cx4, cx5, cx6, cx7;
  logic signed [29:0] b6_1;
  logic signed [59:0] sqf_2;
  logic signed [45:0] a2_2, a3_2;
  logic signed [47:0] sq_3;
  logic signed [34:0] x2a_3, x2a_4;
  logic signed [32:0] x1c_3, x1c_4;
  logic signed [63:0] mb2_4, mb1_4;
  logic signed [B3W-1:0] b3_5;
  logic signed [48:0] xs_5;
  logic signed [65:0] b4m_6;
  logic signed [B3W:0] b7a_6;
  logic signed [50:0] b4_7;
  logic signed [B7W-1:0] b7_7;

  // P5 comb
  logic signed [52:0] x1_p5;
  logic signed [53:0] x3_p5;
  logic signed [54:0] s_p5;
  logic signed [B3SW-1:0] bsum_p5;
  logic signed [47:0] x2b_p5;
  logic signed [49:0] xsum_p5;
  logic signed [47:0] x3b_p5;

  assign x1_p5   = $signed(mb2_4[63:11]);
  assign x3_p5   = 54'(x1_p5) + 54'(x2a_4);
  assign s_p5    = (55'(ac1) <<< 2) + 55'(x3_p5);
  assign bsum_p5 = (B3SW'(s_p5) <<< OVERSAMPLING) + B3SW'(2);
  assign x2b_p5  = $signed(mb1_4[63:16]);
  assign xsum_p5 = 50'(x1c_4) + 50'(x2b_p5) + 50'sd2;
  assign x3b_p5  = $signed(xsum_p5[49:2]);

  // P8 comb
  logic                  err_p8, case2_p8, neg_p8, ovf_p8;
  logic signed [PNW-1:0] nn_p8;
  logic [PNW-1:0]        mag_p8;
  logic [B4_MAGW-1:0]    b4mag_p8;

  assign err_p8   = cx7.terr || (b4_7 <= 51'sd0);
  assign case2_p8 = (b7_7 >= HUGE_B7);
  assign nn_p8    = case2_p8 ? PNW'(b7_7) : (PNW'(b7_7) <<< 1);
  assign neg_p8   = nn_p8[PNW-1];
  assign mag_p8   = neg_p8 ? PNW'(-nn_p8) : nn_p8;
  assign b4mag_p8 = b4_7[B4_MAGW-1:0];
  assign ovf_p8   = PCW'(mag_p8) >= (PCW'(b4mag_p8) << PQ_W);

  logic [PNW-1:0]     num_8;
  logic [B4_MAGW-1:0] den_8;
  pside_t             ps8;

  always_ff @(posedge clk) begin
    if (adv) begin
      cx1.terr <= td_side.terr;
      cx1.tsat <= tsat_p;
      cx1.tout <= tout_p;
      cx1.up   <= td_side.up;
      b6_1     <= 30'(b5_p) - 30'sd4000;

      cx2   <= cx1;
      sqf_2 <= b6_1 * b6_1;
      a2_2  <= b6_1 * ac2;
      a3_2  <= b6_1 * ac3;

      cx3   <= cx2;
      sq_3  <= $signed(sqf_2[59:12]);
      x2a_3 <= $signed(a2_2[45:11]);
      x1c_3 <= $signed(a3_2[45:13]);

      cx4   <= cx3;
      mb2_4 <= sq_3 * b2;
      mb1_4 <= sq_3 * b1;
      x2a_4 <= x2a_3;
      x1c_4 <= x1c_3;

      cx5  <= cx4;
      b3_5 <= $signed(bsum_p5[B3SW-1:2]);
      xs_5 <= 49'(x3b_p5) + 49'sd32768;

      cx6   <= cx5;
      b4m_6 <= xs_5 * $signed({1'b0, ac4});
      b7a_6 <= (B3W+1)'($signed({1'b0, cx5.up})) - (B3W+1)'(b3_5);

      cx7  <= cx6;
      b4_7 <= $signed(b4m_6[65:15]);
      b7_7 <= b7a_6 * PMUL;

      num_8     <= mag_p8;
      den_8     <= b4mag_p8;
      ps8.err   <= err_p8;
      ps8.case2 <= case2_p8;
      ps8.neg   <= neg_p8;
      ps8.ovf   <= ovf_p8;
      ps8.tsat  <= cx7.tsat;
      ps8.tout  <= cx7.tout;
    end
  end

  logic             pd_valid;
  logic [PQ_W-1:0]  pd_q;
  pside_t           pd_side;

  bpc_div #(.NW(PNW), .DW(B4_MAGW), .QW(PQ_W), .SW($bits(pside_t))) u_pdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (vp8),
    .num      (num_8),
    .den      (den_8),
    .side_in  (ps8),
    .out_valid(pd_valid),
    .quo      (pd_q),
    .side_out (pd_side)
  );

  // final correction stages
  logic        vf1, vf2, vf3;
  pside_t      fs1, fs2, fs3;
  logic        huge1, huge2, huge3, negz1, negz2, negz3;
  logic [31:0] p1, p2, p3;
  logic [23:0] ph1;
  logic [47:0] phph2;
  logic [44:0] m7_2;
  logic [59:0] a3f;
  logic signed [29:0] x2f3;
  logic signed [45:0] negm7;

  assign negm7 = -$signed({1'b0, m7_2});

  always_ff @(posedge clk) begin
    if (adv) begin
      fs1   <= pd_side;
      huge1 <= pd_side.ovf || (pd_side.case2 && pd_q[PQ_W-1]);
      negz1 <= pd_side.neg && (pd_side.ovf || (pd_q != '0));
      p1    <= pd_side.case2 ? {pd_q, 1'b0} : {1'b0, pd_q};
      ph1   <= pd_side.case2 ? pd_q[PQ_W-1:7] : {1'b0, pd_q[PQ_W-1:8]};

      fs2   <= fs1;
      huge2 <= huge1;
      negz2 <= negz1;
      p2    <= p1;
      phph2 <= ph1 * ph1;
      m7_2  <= p1 * C_X2;

      fs3   <= fs2;
      huge3 <= huge2;
      negz3 <= negz2;
      p3    <= p2;
      a3f   <= phph2 * C_X1;
      x2f3  <= $signed(negm7[45:16]);
    end
  end

  logic [43:0]        x1f;
  logic signed [45:0] csum;
  logic signed [47:0] pf;
  logic [19:0]        pres_f;
  logic               psat_f;
  result_t            res_f;

  assign x1f  = a3f[59:16];
  assign csum = 46'($signed({1'b0, x1f})) + 46'(x2f3) + 46'sd3791;
  assign pf   = 48'($signed({1'b0, p3})) + 48'($signed(csum[45:4]));

  always_comb begin
    pres_f = '0;
    psat_f = 1'b0;
    if (negz3) begin
      psat_f = 1'b1;
    end else if (huge3) begin
      pres_f = P_MAX;
      psat_f = 1'b1;
    end else if (pf < 48'sd0) begin
      psat_f = 1'b1;
    end else if (pf > 48'sd1048575) begin
      pres_f = P_MAX;
      psat_f = 1'b1;
    end else begin
      pres_f = pf[19:0];
    end
    if (fs3.err) begin
      res_f.temp = '0;
      res_f.pres = '0;
      res_f.st   = STAT_DIV0;
    end else begin
      res_f.temp = fs3.tout;
      res_f.pres = pres_f;
      res_f.st   = (psat_f || fs3.tsat) ? STAT_SAT : STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3} <= '0;
      {vp1, vp2, vp3, vp4, vp5, vp6, vp7, vp8} <= '0;
      {vf1, vf2, vf3} <= '0;
    end else if (adv) begin
      v1  <= in_valid;
      v2  <= v1;
      v3  <= v2;
      vp1 <= td_valid;
      vp2 <= vp1;
      vp3 <= vp2;
      vp4 <= vp3;
      vp5 <= vp4;
      vp6 <= vp5;
      vp7 <= vp6;
      vp8 <= vp7;
      vf1 <= pd_valid;
      vf2 <= vf1;
      vf3 <= vf2;
    end
  end

  // output queue
  result_t fifo_mem [2];
  logic    wp, rp, push, pop;

  assign push = adv && vf3;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wp] <= res_f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_valid          = (cnt != 2'd0);
  assign temperature_tenths = $signed(fifo_mem[rp].temp);
  assign pressure_pa        = fifo_mem[rp].pres;
  assign status             = fifo_mem[rp].st;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output queue count out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv && vf3 |=> vf3 && $stable(p3))
    else $error("pipeline moved while stalled");

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_DIV0 |-> temperature_tenths == 16'sd0 && pressure_pa == '0)
    else $error("divisor error with nonzero result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");
`endif

endmodule
